// ----- sv/cfb_pkg.sv -----
`timescale 1ns / 1ps
package cfb_pkg;

  localparam int SetLen        = 6;
  localparam int FrameLen      = 13;
  localparam int QueueDepthDef = 2;

  localparam int FrameIdxW = $clog2(FrameLen);
  localparam int PayIdxW   = $clog2(SetLen);
  localparam int SumW      = 7;

  typedef logic [7:0] cmd_byte_t;
  typedef logic [SetLen-1:0][7:0] cmd_set_t;
  typedef logic [FrameIdxW-1:0] frame_idx_t;

  typedef enum logic [1:0] {
    OP_STORE_NAV   = 2'd0,
    OP_STORE_MANIP = 2'd1,
    OP_SEND        = 2'd2
  } op_t;

  // frame positions
  localparam frame_idx_t FrameIdxSync0      = FrameIdxW'(0);
  localparam frame_idx_t FrameIdxSync1      = FrameIdxW'(1);
  localparam frame_idx_t FrameIdxPad        = FrameIdxW'(2);
  localparam frame_idx_t FrameIdxLen        = FrameIdxW'(3);
  localparam frame_idx_t FrameIdxDrive      = FrameIdxW'(4);
  localparam frame_idx_t FrameIdxAuto       = FrameIdxW'(5);
  localparam frame_idx_t FrameIdxPayload    = FrameIdxW'(6);
  localparam frame_idx_t FrameIdxPayloadEnd = FrameIdxW'(11);
  localparam frame_idx_t FrameIdxLast       = FrameIdxW'(FrameLen - 1);

  localparam cmd_byte_t ByteG       = 8'h47;
  localparam cmd_byte_t ByteO       = 8'h4F;
  localparam cmd_byte_t ByteZero    = 8'h00;
  localparam cmd_byte_t ByteLen     = 8'd8;
  localparam cmd_byte_t ByteOn      = 8'hFF;
  localparam cmd_byte_t ByteNeutral = 8'd127;
  localparam cmd_byte_t ByteManip   = 8'd100;
  localparam cmd_byte_t ByteGrip    = 8'd95;
  localparam cmd_byte_t ChecksumMax = 8'd72;

  localparam cmd_set_t NavReset   = {SetLen{ByteNeutral}};
  localparam cmd_set_t ManipReset = {ByteManip, ByteManip, ByteGrip,
                                     ByteManip, ByteManip, ByteManip};

  typedef struct packed {
    logic [1:0] operation;
    logic       drive_switch;
    logic       auto_switch;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic     drive_on;
    logic     auto_on;
    cmd_set_t payload;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       active;
    frame_idx_t idx;
  } back_stat_t;

  function automatic logic [3:0] ones_in_byte(input cmd_byte_t v);
    logic [3:0] n;
    n = '0;
    for (int b = 0; b < 8; b++) begin
      n = n + 4'(v[b]);
    end
    return n;
  endfunction

endpackage

// ----- sv/cfb_front.sv -----
`timescale 1ns / 1ps
module cfb_front
  import cfb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output logic     push,
  output job_t     job
);

  cmd_set_t nav_r, nav_nxt;
  cmd_set_t manip_r, manip_nxt;
  cmd_set_t new_set;

  assign new_set = {item.byte_5, item.byte_4, item.byte_3,
                    item.byte_2, item.byte_1, item.byte_0};

  always_comb begin
    nav_nxt   = nav_r;
    manip_nxt = manip_r;
    push      = 1'b0;
    if (take) begin
      unique case (item.operation)
        OP_STORE_NAV:   nav_nxt   = new_set;
        OP_STORE_MANIP: manip_nxt = new_set;
        OP_SEND:        push      = 1'b1;
        default:        ;
      endcase
    end
  end

  // payload snapshot taken at accept time
  always_comb begin
    job.drive_on = item.drive_switch;
    job.auto_on  = item.auto_switch;
    if (!item.drive_switch) begin
      job.payload = manip_r;
    end else if (!item.auto_switch) begin
      job.payload = nav_r;
    end else begin
      job.payload = NavReset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nav_r   <= NavReset;
      manip_r <= ManipReset;
    end else begin
      nav_r   <= nav_nxt;
      manip_r <= manip_nxt;
    end
  end

endmodule

// ----- sv/cfb_queue.sv -----
`timescale 1ns / 1ps
module cfb_queue
  import cfb_pkg::*;
#(
  parameter int DEPTH = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CntW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- sv/cfb_back.sv -----
`timescale 1ns / 1ps
module cfb_back
  import cfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  job_t       head,
  output logic       pop,
  output back_stat_t stat,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic            active_r, active_nxt;
  frame_idx_t      idx_r, idx_nxt;
  job_t            job_r, job_nxt;
  logic [SumW-1:0] sum_r, sum_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  cmd_byte_t       cur_byte;
  frame_idx_t      pay_off;

  assign pay_off = idx_r - FrameIdxPayload;

  always_comb begin
    case (idx_r) inside
      FrameIdxSync0: cur_byte = ByteG;
      FrameIdxSync1: cur_byte = ByteO;
      FrameIdxPad:   cur_byte = ByteZero;
      FrameIdxLen:   cur_byte = ByteLen;
      FrameIdxDrive: cur_byte = job_r.drive_on ? ByteOn : ByteZero;
      FrameIdxAuto:  cur_byte = job_r.auto_on ? ByteOn : ByteZero;
      [FrameIdxPayload:FrameIdxPayloadEnd]:
                     cur_byte = job_r.payload[pay_off[PayIdxW-1:0]];
      FrameIdxLast:  cur_byte = {1'b0, sum_r};
      default:       cur_byte = ByteZero;
    endcase
  end

  assign pop = !q_stat.empty && (!active_r || idx_r == FrameIdxLast);

  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    job_nxt       = job_r;
    sum_nxt       = sum_r;
    out_valid_nxt = active_r;
    out_data_nxt  = out_data_r;
    if (active_r) begin
      out_data_nxt.frame_byte = cur_byte;
      out_data_nxt.frame_end  = (idx_r == FrameIdxLast);
      if (idx_r >= FrameIdxLen && idx_r <= FrameIdxPayloadEnd) begin
        sum_nxt = sum_r + SumW'(ones_in_byte(cur_byte));
      end
      idx_nxt = idx_r + 1'b1;
      if (idx_r == FrameIdxLast) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      job_nxt    = head;
      sum_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.active = active_r;
  assign stat.idx    = idx_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

endmodule

// ----- sv/control_frame_builder_top.sv -----
`timescale 1ns / 1ps
// channel | ports                        | handshake
// --------+------------------------------+------------------------------------------
// input   | start, busy, in_data         | word taken at edge with start & !busy
// result  | out_valid, out_data          | word shown one cycle, taken at its end
//
// a send word yields 13 result words, one per cycle, set by the byte serializer
// first byte of a frame leaves after the send is queued, loaded by the serializer and registered at the output
// frames queued back to back follow each other with no gap
// store words yield nothing; busy is high while the job queue is full
// reset is synchronous, active low; it restores both command sets and empties the queue
// the receiver cannot stall: results are never held off
module control_frame_builder_top
  import cfb_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  logic       take;
  logic       push;
  logic       pop;
  job_t       push_job;
  job_t       head;
  q_stat_t    q_stat;
  back_stat_t b_stat;

  // front stalls only when no queue slot is free
  assign busy = q_stat.full;
  assign take = start && !busy;

  // front: holds the command sets, classifies words, snapshots the payload on send
  cfb_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (in_data),
    .push  (push),
    .job   (push_job)
  );

  // short job queue between classifier and serializer
  cfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // back: serializes one frame, accumulating the checksum on the fly
  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .stat      (b_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // serializer walks the frame one position per cycle until the checksum byte
  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    b_stat.active && b_stat.idx != FrameIdxLast |=>
      b_stat.active && b_stat.idx == $past(b_stat.idx) + 1'b1)
    else $error("frame position skipped or stalled");

  // checksum over nine bytes cannot exceed 72
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.frame_byte <= ChecksumMax)
    else $error("checksum out of range");

  // a taken send always leaves a job waiting for the serializer
  a_send_queued: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_data.operation == OP_SEND |=> !q_stat.empty)
    else $error("send word lost before queue");

  // a pop only happens when the serializer is free or finishing
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !b_stat.active || b_stat.idx == FrameIdxLast)
    else $error("job popped during a frame");

endmodule
